// ===== hw/rtl/tcrq_pkg.sv =====
package tcrq_pkg;

  typedef logic [16:0] reg_num_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] base_address;
    logic [7:0]  byte_offset;
    logic [7:0]  write_data;
    logic [14:0] touch_x;
    logic [14:0] touch_y;
    logic [2:0]  button_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bad_address;
    logic       interrupt_raise;
    logic       message_dropped;
  } result_t;

  localparam int WR_COUNT = 40;
  localparam int WR_AW = 6;
  localparam int MSG_W = 32;
  localparam int QUEUE_SLOTS_DEFAULT = 10;
  localparam int COORD_W = 15;
  localparam int POS_W = 17;

  // write port of the configuration byte store
  typedef struct packed {
    logic             en;
    logic [WR_AW-1:0] addr;
    logic [7:0]       data;
  } wb_wr_t;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TOUCH = 2'd2;

  localparam reg_num_t MAP_SIZE   = 17'd153;
  localparam reg_num_t MSG_FIRST  = 17'd104;
  localparam reg_num_t MSG_LAST   = 17'd112;
  localparam reg_num_t WR_FIRST   = 17'd113;
  localparam reg_num_t ORIENT_REG = 17'd122;
  localparam reg_num_t XR_LSB     = 17'd131;
  localparam reg_num_t XR_MSB     = 17'd132;
  localparam reg_num_t YR_LSB     = 17'd133;
  localparam reg_num_t YR_MSB     = 17'd134;

  // byte positions within the message window
  localparam logic [3:0] MSG_K_ID     = 4'd0;
  localparam logic [3:0] MSG_K_STATUS = 4'd1;
  localparam logic [3:0] MSG_K_XHI    = 4'd2;
  localparam logic [3:0] MSG_K_YHI    = 4'd3;
  localparam logic [3:0] MSG_K_LO     = 4'd4;
  localparam logic [3:0] MSG_K_AREA   = 4'd5;

  localparam logic [7:0] ST_PRESS   = 8'hC0;
  localparam logic [7:0] ST_RELEASE = 8'h20;
  localparam logic [7:0] ST_MOVE    = 8'h90;
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  localparam logic [COORD_W-1:0] FULL_SCALE = 15'h7FFF;

  localparam int IMAGE_LEN = 31;
  localparam logic [7:0] FIXED_IMAGE [IMAGE_LEN] = '{
    8'h80, 8'h00, 8'h11, 8'h00, 8'd16, 8'd14, 8'd4,
    8'd5, 8'h68, 8'h00, 8'd8, 8'd0, 8'd0,
    8'd9, 8'h71, 8'h00, 8'd29, 8'd0, 8'd10,
    8'd28, 8'h94, 8'h00, 8'd4, 8'd0, 8'd0,
    8'd6, 8'h8F, 8'h00, 8'd4, 8'd0, 8'd0
  };

  // identity and object table, zero past the listed bytes
  function automatic logic [7:0] fixed_byte(input logic [6:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 7'(IMAGE_LEN)) begin
      b = FIXED_IMAGE[idx[4:0]];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/tcrq_wb_mem.sv =====
module tcrq_wb_mem
  import tcrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  wb_wr_t           wr,
  input  logic             re,
  input  logic [WR_AW-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0]          mem [WR_COUNT];
  logic [WR_COUNT-1:0] vld;
  logic [7:0]          rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : 8'h00;

endmodule

// ===== hw/rtl/tcrq_msg_mem.sv =====
module tcrq_msg_mem
  import tcrq_pkg::*;
#(
  parameter int DEPTH = QUEUE_SLOTS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [MSG_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [MSG_W-1:0] rdata
);

  logic [MSG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tcrq_scale.sv =====
module tcrq_scale
  import tcrq_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [COORD_W-1:0] touch_x,
  input  logic [COORD_W-1:0] touch_y,
  input  logic [POS_W-1:0]   x_scale,
  input  logic [POS_W-1:0]   y_scale,
  output logic [POS_W-1:0]   x_pos,
  output logic [POS_W-1:0]   y_pos
);

  localparam int PROD_W = COORD_W + POS_W;

  logic [PROD_W-1:0] x_prod;
  logic [PROD_W-1:0] y_prod;

  // floor(p / (2^15 - 1)) by folding the high part back onto the low part
  function automatic logic [POS_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
    logic [POS_W-1:0]   hi;
    logic [POS_W:0]     s;
    logic [2:0]         s_hi;
    logic [COORD_W:0]   t;
    logic               carry;
    hi    = p[PROD_W-1:COORD_W];
    s     = {1'b0, hi} + (POS_W+1)'(p[COORD_W-1:0]);
    s_hi  = s[POS_W:COORD_W];
    t     = (COORD_W+1)'(s_hi) + {1'b0, s[COORD_W-1:0]};
    carry = (t >= {1'b0, FULL_SCALE});
    return hi + POS_W'(s_hi) + POS_W'(carry);
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      x_prod <= PROD_W'(touch_x) * PROD_W'(x_scale);
      y_prod <= PROD_W'(touch_y) * PROD_W'(y_scale);
    end
  end

  assign x_pos = div_full_scale(x_prod);
  assign y_pos = div_full_scale(y_prod);

endmodule

// ===== hw/rtl/touch_controller_register_queue.sv =====
// Touch controller behind a 153-byte register map, with a message queue.
// Each item has an accept cycle and a busy cycle: the accept cycle reads
// the configuration byte store and the message store at the queue head
// and registers the two coordinate products; the busy cycle finishes the
// scaling, forms the result and writes back the byte store, the message
// store and the queue pointers. No item is taken while busy, and only
// once the result register is free or being taken. Reads of message byte
// 112 pop the queue; a full queue drops the new message and flags it.
// There is no start-up sweep; valid bits mark written byte store entries.
module touch_controller_register_queue
  import tcrq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int PTR_W = $clog2(QUEUE_SLOTS);

  logic             accept;
  logic             busy;
  item_t            cur;
  reg_num_t         cur_reg;
  reg_num_t         item_reg;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             axes_swapped, axes_swapped_next;
  logic [POS_W-1:0] x_scale, x_scale_next;
  logic [POS_W-1:0] y_scale, y_scale_next;
  logic             touching, touching_next;
  logic [POS_W-1:0] last_x, last_x_next;
  logic [POS_W-1:0] last_y, last_y_next;
  logic [7:0]       xr_lsb, xr_lsb_next;
  logic [7:0]       xr_msb, xr_msb_next;
  logic [7:0]       yr_lsb, yr_lsb_next;
  logic [7:0]       yr_msb, yr_msb_next;
  result_t          res_next;

  wb_wr_t           wb_wr;
  logic [7:0]       wb_rdata;
  logic             msg_we;
  logic [MSG_W-1:0] msg_wdata;
  logic [MSG_W-1:0] msg_rdata;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;

  logic [3:0]       msg_k;
  logic             pressed;
  logic [7:0]       status;
  logic             push;
  logic [PTR_W-1:0] tail_inc;
  logic [POS_W-1:0] xr_value;
  logic [POS_W-1:0] yr_value;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign item_stall = busy | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;
  assign item_reg   = {1'b0, item.base_address} + 17'(item.byte_offset);

  tcrq_wb_mem u_wb_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (wb_wr),
    .re    (accept),
    .raddr (WR_AW'(item_reg - WR_FIRST)),
    .rdata (wb_rdata)
  );

  tcrq_msg_mem #(
    .DEPTH (QUEUE_SLOTS)
  ) u_msg_mem (
    .clk   (clk),
    .we    (msg_we),
    .waddr (tail),
    .wdata (msg_wdata),
    .re    (accept),
    .raddr (head),
    .rdata (msg_rdata)
  );

  tcrq_scale u_scale (
    .clk     (clk),
    .load    (accept),
    .touch_x (item.touch_x),
    .touch_y (item.touch_y),
    .x_scale (x_scale),
    .y_scale (y_scale),
    .x_pos   (x_pos),
    .y_pos   (y_pos)
  );

  assign msg_k    = 4'(cur_reg - MSG_FIRST);
  assign pressed  = |cur.button_bits;
  assign tail_inc = ptr_inc(tail);

  always_comb begin
    head_next         = head;
    tail_next         = tail;
    axes_swapped_next = axes_swapped;
    x_scale_next      = x_scale;
    y_scale_next      = y_scale;
    touching_next     = touching;
    last_x_next       = last_x;
    last_y_next       = last_y;
    xr_lsb_next       = xr_lsb;
    xr_msb_next       = xr_msb;
    yr_lsb_next       = yr_lsb;
    yr_msb_next       = yr_msb;
    xr_value          = '0;
    yr_value          = '0;
    res_next          = '0;
    wb_wr             = '0;
    status            = ST_MOVE;
    push              = 1'b0;
    msg_we            = 1'b0;
    msg_wdata         = {status, x_pos[9:2], y_pos[9:2],
                         x_pos[1:0], 2'b00, y_pos[1:0], 2'b00};

    case (cur.kind)
      KIND_READ: begin
        if (cur_reg >= MAP_SIZE) begin
          res_next.bad_address = 1'b1;
        end else if (cur_reg < MSG_FIRST) begin
          res_next.read_data = fixed_byte(cur_reg[6:0]);
        end else if (cur_reg <= MSG_LAST) begin
          if (head == tail) begin
            res_next.read_data = EMPTY_BYTE;
          end else begin
            case (msg_k)
              MSG_K_ID, MSG_K_AREA: res_next.read_data = 8'h01;
              MSG_K_STATUS:         res_next.read_data = msg_rdata[31:24];
              MSG_K_XHI:            res_next.read_data = msg_rdata[23:16];
              MSG_K_YHI:            res_next.read_data = msg_rdata[15:8];
              MSG_K_LO:             res_next.read_data = msg_rdata[7:0];
              default:              res_next.read_data = 8'h00;
            endcase
            // last message byte pops the head
            if (cur_reg == MSG_LAST) begin
              head_next = ptr_inc(head);
            end
          end
        end else begin
          res_next.read_data = wb_rdata;
        end
      end
      KIND_WRITE: begin
        if (cur_reg >= WR_FIRST && cur_reg < MAP_SIZE) begin
          wb_wr.en   = 1'b1;
          wb_wr.addr = WR_AW'(cur_reg - WR_FIRST);
          wb_wr.data = cur.write_data;
          if (cur_reg == ORIENT_REG) begin
            axes_swapped_next = cur.write_data[0];
          end
          if (cur_reg == XR_LSB) begin
            xr_lsb_next = cur.write_data;
          end
          if (cur_reg == XR_MSB) begin
            xr_msb_next = cur.write_data;
          end
          if (cur_reg == YR_LSB) begin
            yr_lsb_next = cur.write_data;
          end
          if (cur_reg == YR_MSB) begin
            yr_msb_next = cur.write_data;
          end
          xr_value = {1'b0, xr_msb_next, xr_lsb_next} + 17'd1;
          yr_value = {1'b0, yr_msb_next, yr_lsb_next} + 17'd1;
          if (cur_reg == XR_LSB || cur_reg == XR_MSB) begin
            if (axes_swapped) begin
              y_scale_next = xr_value;
            end else begin
              x_scale_next = xr_value;
            end
          end
          if (cur_reg == YR_LSB || cur_reg == YR_MSB) begin
            if (axes_swapped) begin
              x_scale_next = yr_value;
            end else begin
              y_scale_next = yr_value;
            end
          end
        end else begin
          res_next.bad_address = 1'b1;
        end
      end
      KIND_TOUCH: begin
        if (pressed != touching) begin
          push   = 1'b1;
          status = pressed ? ST_PRESS : ST_RELEASE;
        end else if (touching && (x_pos != last_x || y_pos != last_y)) begin
          push   = 1'b1;
          status = ST_MOVE;
        end
        msg_wdata = {status, x_pos[9:2], y_pos[9:2],
                     x_pos[1:0], 2'b00, y_pos[1:0], 2'b00};
        if (push) begin
          res_next.interrupt_raise = 1'b1;
          if (tail_inc == head) begin
            res_next.message_dropped = 1'b1;
          end else begin
            msg_we    = 1'b1;
            tail_next = tail_inc;
          end
        end
        touching_next = pressed;
        last_x_next   = x_pos;
        last_y_next   = y_pos;
      end
      default: begin
      end
    endcase

    if (!busy) begin
      wb_wr.en = 1'b0;
      msg_we   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= item;
      cur_reg <= item_reg;
    end
    if (busy) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
      head         <= '0;
      tail         <= '0;
      axes_swapped <= 1'b0;
      x_scale      <= 17'd1;
      y_scale      <= 17'd1;
      touching     <= 1'b0;
      last_x       <= '0;
      last_y       <= '0;
      xr_lsb       <= '0;
      xr_msb       <= '0;
      yr_lsb       <= '0;
      yr_msb       <= '0;
    end else begin
      busy <= accept;
      if (busy) begin
        result_valid <= 1'b1;
        head         <= head_next;
        tail         <= tail_next;
        axes_swapped <= axes_swapped_next;
        x_scale      <= x_scale_next;
        y_scale      <= y_scale_next;
        touching     <= touching_next;
        last_x       <= last_x_next;
        last_y       <= last_y_next;
        xr_lsb       <= xr_lsb_next;
        xr_msb       <= xr_msb_next;
        yr_lsb       <= yr_lsb_next;
        yr_msb       <= yr_msb_next;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/tcrq_checker.sv =====
module tcrq_checker
  import tcrq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a held result does not change
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // an accepted item blocks the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken in the cycle after a transfer");

  // a drop only comes with a raised interrupt
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.message_dropped |-> result.interrupt_raise)
    else $error("message dropped without interrupt");

  // address errors and touch reports return no data and never come together
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.bad_address || result.interrupt_raise)
      |-> result.read_data == 8'h00 && !(result.bad_address && result.interrupt_raise))
    else $error("inconsistent result flags");

endmodule

bind touch_controller_register_queue tcrq_checker u_tcrq_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
